// ----- sv/mk_pkg.sv -----
// Shared types, constants and the letter lookup for the Morse keyer.
package mk_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned DotW  = 12;
	localparam int unsigned DurW  = 15;
	localparam int unsigned BitsW = 4;
	localparam int unsigned LenW  = 3;
	localparam int unsigned SymW  = 2;

	localparam logic [DotW-1:0]  DotReset   = 12'd200;
	localparam logic [CharW-1:0] CodeSpace  = 8'd32;
	localparam logic [CharW-1:0] CodeUpperA = 8'd65;
	localparam logic [CharW-1:0] CodeUpperZ = 8'd90;
	localparam logic [CharW-1:0] CodeLowerA = 8'd97;
	localparam logic [CharW-1:0] CodeLowerZ = 8'd122;
	localparam logic [CharW-1:0] CaseBit    = 8'h20;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} mk_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_results;
		logic out_free;
		logic final_result;
	} mk_sts_t;

	// Low nibble is the dash mask with the first symbol in bit 0, high bits the length.
	localparam logic [7:0] LetterTable [26] = '{
		8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
		8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
		8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
	};

	function automatic logic [7:0] letter_entry(input logic [4:0] idx);
		logic [7:0] e;
		e = 8'h00;
		if (idx < 5'd26) begin
			e = LetterTable[idx];
		end
		return e;
	endfunction

endpackage

// ----- sv/mk_ctrl.sv -----
// Controller state machine: takes a character, then steps out its results.
module mk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  mk_pkg::mk_sts_t sts,
	output mk_pkg::mk_cmd_t cmd
);
	import mk_pkg::*;

	localparam logic StIdle = 1'b0;
	localparam logic StEmit = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			StIdle: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.has_results) begin
						state_d = StEmit;
					end
				end
			end
			StEmit: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.final_result) begin
						state_d = StIdle;
					end
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/mk_datapath.sv -----
// Datapath: character decode, pattern registers, durations and the output register.
module mk_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mk_pkg::CharW-1:0]   char_code,
	input  logic                       cfg_we,
	input  logic [mk_pkg::DotW-1:0]    cfg_wdata,
	input  mk_pkg::mk_cmd_t            cmd,
	output mk_pkg::mk_sts_t            sts,
	input  logic                       out_taken,
	output logic                       out_valid,
	output logic                       key_on,
	output logic [mk_pkg::DurW-1:0]    duration_ms,
	output logic                       last_of_char
);
	import mk_pkg::*;

	logic [DotW-1:0]  dot_q;
	logic [BitsW-1:0] bits_q;
	logic [LenW-1:0]  len_q;
	logic [SymW-1:0]  sym_q;
	logic             phase_q;
	logic             space_q;
	logic             out_valid_q;
	logic             key_on_q;
	logic [DurW-1:0]  dur_q;
	logic             last_q;

	logic [CharW-1:0] folded;
	logic             is_letter;
	logic             is_space;
	logic [7:0]       entry;
	logic [CharW-1:0] letter_off;
	logic [DurW-1:0]  dur1;
	logic [DurW-1:0]  dur3;
	logic [DurW-1:0]  dur7;
	logic             cur_key;
	logic [DurW-1:0]  cur_dur;
	logic             cur_last;

	// Upper case is folded to lower case before the lookup.
	always_comb begin
		folded = char_code;
		if (char_code inside {[CodeUpperA:CodeUpperZ]}) begin
			folded = char_code | CaseBit;
		end
		is_letter  = folded inside {[CodeLowerA:CodeLowerZ]};
		is_space   = (folded == CodeSpace);
		letter_off = folded - CodeLowerA;
		entry      = letter_entry(letter_off[4:0]);
	end

	assign dur1 = {{(DurW-DotW){1'b0}}, dot_q};
	assign dur3 = dur1 + {dur1[DurW-2:0], 1'b0};
	assign dur7 = {dur1[DurW-4:0], 3'b000} - dur1;

	// Each symbol gives a key-down word followed by a key-up gap word.
	always_comb begin
		if (space_q) begin
			cur_key  = 1'b0;
			cur_dur  = dur7;
			cur_last = 1'b1;
		end else if (!phase_q) begin
			cur_key  = 1'b1;
			cur_dur  = bits_q[sym_q] ? dur3 : dur1;
			cur_last = 1'b0;
		end else begin
			cur_key  = 1'b0;
			cur_dur  = dur3;
			cur_last = ({1'b0, sym_q} + 3'd1) == len_q;
		end
	end

	assign sts.has_results  = is_letter || is_space;
	assign sts.out_free     = !out_valid_q || out_taken;
	assign sts.final_result = cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= DotReset;
			bits_q      <= '0;
			len_q       <= '0;
			sym_q       <= '0;
			phase_q     <= 1'b0;
			space_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dot_q <= cfg_wdata;
			end
			if (cmd.load) begin
				bits_q  <= is_letter ? entry[BitsW-1:0] : '0;
				len_q   <= is_letter ? entry[BitsW+LenW-1:BitsW] : '0;
				sym_q   <= '0;
				phase_q <= 1'b0;
				space_q <= is_space;
			end else if (cmd.emit) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					sym_q <= sym_q + 2'd1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			key_on_q <= cur_key;
			dur_q    <= cur_dur;
			last_q   <= cur_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign key_on       = key_on_q;
	assign duration_ms  = dur_q;
	assign last_of_char = last_q;

endmodule

// ----- sv/morse_keyer.sv -----
// Top level of the Morse keyer: controller and datapath joined by command and status.
//
// One ASCII character enters per word on the slave stream (s_tdata). Upper case
// is folded to lower case. A letter gives two master words per Morse symbol: a
// key-down word of one dot time (dot) or three (dash), then a key-up word of three
// dot times. A space gives one key-up word of seven dot times. Any other byte
// gives no words. The final word of a character carries m_tlast; m_tuser is the
// key level and m_tdata the hold time in milliseconds.
// The dot time must be written through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this. A character is taken into the pattern
// registers, then the sequencer fills the single output register one result word
// per cycle while the receiver takes each word, up to eight words for a letter. The
// next character is accepted as soon as the last word of the previous one has
// been loaded, even while it still waits.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset empties the output, returns the sequencer to idle and
// sets the dot time to 200 ms.
module morse_keyer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [14:0] duration_ms, [15] zero
	output logic [0:0]  m_tuser,   // [0] key_on
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);
	import mk_pkg::*;

	mk_cmd_t         cmd;
	mk_sts_t         sts;
	logic [DurW-1:0] duration_ms;
	logic            key_on;

	mk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mk_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (s_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.out_taken    (m_tready),
		.out_valid    (m_tvalid),
		.key_on       (key_on),
		.duration_ms  (duration_ms),
		.last_of_char (m_tlast)
	);

	assign m_tdata = {1'b0, duration_ms};
	assign m_tuser = key_on;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the Morse keyer: directed table, random traffic, predictor.
module tb_top;
	import mk_pkg::*;

	typedef struct packed {
		logic        key_on;
		logic [14:0] hold_ms;
		logic        last;
	} keying_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		logic [1:0] count;
		keying_t    first;
		keying_t    second;
	} stim_row_t;

	localparam int      NumDirected   = 24;
	localparam int      NumPhases     = 5;
	localparam int      ItemsPerPhase = 41;
	localparam int      WatchdogLimit = 1000;
	localparam int      SettleCycles  = 8;
	localparam int      DrainCycles   = 16;
	localparam keying_t NoKey         = '0;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [11:0] cfg_wdata = '0;

	// Predictor state: the dot time currently held by the block.
	logic [11:0] dot_ms = DotReset;
	keying_t     expected_keys [$];
	int          fail_count  = 0;
	int          idle_cycles = 0;

	// What the sender offers with the word on the slave side.
	logic        offer_typed  = 1'b0;
	logic [1:0]  offer_count  = '0;
	keying_t     offer_first  = NoKey;
	keying_t     offer_second = NoKey;

	logic [7:0]  stall_pattern = 8'hFF;
	logic [5:0]  stall_step    = '0;

	stim_row_t   directed_rows [NumDirected];
	logic [11:0] phase_dot [NumPhases];

	string morse_table [26] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--.."
	};

	morse_keyer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic keying_t key_word(input logic on, input logic [14:0] ms, input logic fin);
		keying_t w;
		w = {on, ms, fin};
		return w;
	endfunction

	// Appends the key words (level, hold time and last flag) that one character should produce at the present dot time.
	function automatic void predict_keying(input logic [7:0] code);
		logic [7:0]  c;
		logic [14:0] unit;
		string       pat;
		int          i;
		c = code;
		unit = {3'b000, dot_ms};
		if (c >= CodeUpperA && c <= CodeUpperZ) begin
			c = c + CaseBit;
		end
		if (c >= CodeLowerA && c <= CodeLowerZ) begin
			pat = morse_table[int'(c - CodeLowerA)];
			for (i = 0; i < pat.len(); i++) begin
				expected_keys.push_back(key_word(1'b1,
					(pat[i] == "-") ? unit * 15'd3 : unit, 1'b0));
				expected_keys.push_back(key_word(1'b0, unit * 15'd3,
					i == pat.len() - 1));
			end
		end else if (c == CodeSpace) begin
			expected_keys.push_back(key_word(1'b0, unit * 15'd7, 1'b1));
		end
	endfunction

	function automatic logic [7:0] random_char();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return CodeLowerA + 8'($urandom_range(25));
		end else if (pick < 65) begin
			return CodeUpperA + 8'($urandom_range(25));
		end else if (pick < 80) begin
			return CodeSpace;
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic note_mismatch(input string what, input keying_t want, input keying_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t %s: expected key_on=%0d hold=%0d last=%0d, got key_on=%0d hold=%0d last=%0d",
				$realtime, what, want.key_on, want.hold_ms, want.last,
				got.key_on, got.hold_ms, got.last);
		end
	endtask

	// Presents one character, with a random gap first when the current burst has run out.
	task automatic send_char(input logic [7:0] c, inout int burst_left);
		int gap;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				s_tdata = 8'($urandom_range(255));
				repeat (gap) @(negedge clk);
			end
		end
		s_tdata = c;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
	endtask

	// The dot time may only change once every expected word has come out.
	task automatic write_dot(input logic [11:0] value);
		s_tvalid = 1'b0;
		while (expected_keys.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = 12'($urandom_range(4095));
		dot_ms = value;
	endtask

	// Receiver: stalls on an eight-bit ready pattern, re-drawn whenever the six-bit step counter wraps.
	always @(negedge clk) begin
		int unsigned pick;
		if (stall_step == 0) begin
			pick = $urandom_range(3);
			if (pick == 0) begin
				stall_pattern = 8'hFF;
			end else begin
				stall_pattern = 8'($urandom);
				stall_pattern[0] = 1'b1;
			end
		end
		m_tready = stall_pattern[stall_step[2:0]];
		stall_step = stall_step + 6'd1;
	end

	// Checks every master word against the oldest expectation, then books new characters.
	always @(posedge clk) begin
		keying_t got;
		keying_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = key_word(m_tuser[0], m_tdata[14:0], m_tlast);
			if (expected_keys.size() == 0) begin
				note_mismatch("word with nothing expected", NoKey, got);
			end else begin
				want = expected_keys.pop_front();
				if (got.key_on !== want.key_on || got.hold_ms !== want.hold_ms ||
				    got.last !== want.last || m_tdata[15] !== 1'b0) begin
					note_mismatch("word mismatch", want, got);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			if (offer_typed) begin
				if (offer_count > 0) begin
					expected_keys.push_back(offer_first);
				end
				if (offer_count > 1) begin
					expected_keys.push_back(offer_second);
				end
			end else begin
				predict_keying(s_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int burst_left;
		int k;
		int phase;
		stim_row_t row;

		// Typed rows assume the reset dot time of 200 ms.
		directed_rows = '{
			'{8'h65, 1'b1, 2'd2, key_word(1'b1, 15'd200, 1'b0), key_word(1'b0, 15'd600, 1'b1)},
			'{8'h45, 1'b1, 2'd2, key_word(1'b1, 15'd200, 1'b0), key_word(1'b0, 15'd600, 1'b1)},
			'{8'h74, 1'b1, 2'd2, key_word(1'b1, 15'd600, 1'b0), key_word(1'b0, 15'd600, 1'b1)},
			'{8'h54, 1'b1, 2'd2, key_word(1'b1, 15'd600, 1'b0), key_word(1'b0, 15'd600, 1'b1)},
			'{8'h20, 1'b1, 2'd1, key_word(1'b0, 15'd1400, 1'b1), NoKey},
			'{8'h20, 1'b1, 2'd1, key_word(1'b0, 15'd1400, 1'b1), NoKey},
			'{8'h00, 1'b1, 2'd0, NoKey, NoKey},
			'{8'hFF, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h80, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h30, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h40, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h5B, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h60, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h7B, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h7F, 1'b1, 2'd0, NoKey, NoKey},
			'{8'h61, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h5A, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h41, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h7A, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h68, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h6A, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h71, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h79, 1'b0, 2'd0, NoKey, NoKey},
			'{8'h6F, 1'b0, 2'd0, NoKey, NoKey}
		};
		// A zero dot time is accepted as it stands and gives zero-length words.
		phase_dot = '{12'd1, 12'hFFF, 12'd0, 12'd0, DotReset};
		phase_dot[3] = 12'($urandom_range(1, 4095));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		burst_left = 0;
		for (k = 0; k < NumDirected; k++) begin
			row = directed_rows[k];
			offer_typed = row.typed;
			offer_count = row.count;
			offer_first = row.first;
			offer_second = row.second;
			send_char(row.ch, burst_left);
		end

		offer_typed = 1'b0;
		for (phase = 0; phase < NumPhases; phase++) begin
			write_dot(phase_dot[phase]);
			burst_left = 0;
			for (k = 0; k < ItemsPerPhase; k++) begin
				send_char(random_char(), burst_left);
			end
		end

		s_tvalid = 1'b0;
		while (expected_keys.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && expected_keys.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
